### rtl/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants for the nearest palette color search block.
// ----------------------------------------------------------------------------
package npc_pkg;

    // Width of one color channel and of a packed palette word
    localparam int CHAN_W = 6;
    localparam int WORD_W = 3 * CHAN_W;

    // Squared distance: three squared 4-bit quotients sum to at most 675
    localparam int DIST_W  = 10;
    // Running best starts above any reachable distance
    localparam int BEST_W  = 14;
    localparam logic [BEST_W-1:0] START_BOUND = 14'd12000;

    // Operation codes carried on tuser
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_HOLD
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // write one palette entry
        logic start;     // capture query color, clear running best
        logic scan;      // read entry at scan address, advance address
        logic out_load;  // move best index into the output register
    } npc_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic last_addr; // scan address points at the final entry
    } npc_status_t;

endpackage

### rtl/npc_ctrl.sv
// ----------------------------------------------------------------------------
// npc_ctrl
// Controller: sequences loads, the palette scan and the result handoff.
// ----------------------------------------------------------------------------
module npc_ctrl
    import npc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_func,
    output logic        in_ready,
    input  logic        out_ready,
    output logic        out_valid,
    input  npc_status_t status,
    output npc_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // State and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_func == FUNC_QUERY)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.last_addr)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                // final compare completes this cycle
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until the beat is taken
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/npc_dpath.sv
// ----------------------------------------------------------------------------
// npc_dpath
// Datapath: palette memory, per-entry distance, running minimum, result.
// ----------------------------------------------------------------------------
module npc_dpath
    import npc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  npc_cmd_t          cmd,
    output npc_status_t       status,
    input  logic [CHAN_W-1:0] entry_index,
    input  logic [CHAN_W-1:0] red,
    input  logic [CHAN_W-1:0] green,
    input  logic [CHAN_W-1:0] blue,
    output logic [CHAN_W-1:0] nearest_index
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

    logic [WORD_W-1:0] mem [PALETTE_ENTRIES];

    logic [CHAN_W-1:0] qry_r_reg;
    logic [CHAN_W-1:0] qry_g_reg;
    logic [CHAN_W-1:0] qry_b_reg;
    logic [IDX_W-1:0]  addr_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic              cmp_valid_reg;
    logic [BEST_W-1:0] best_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [CHAN_W-1:0] out_data_reg;

    logic [IDX_W-1:0]        wr_addr;
    logic                    wr_in_range;
    logic [IDX_W+CHAN_W-1:0] wr_addr_ext;
    logic [IDX_W+CHAN_W-1:0] best_idx_ext;
    logic [DIST_W-1:0]       distance;
    logic                    better;

    // Absolute difference divided by 4 (truncation toward zero), squared
    function automatic logic [7:0] chan_sq(input logic [CHAN_W-1:0] q,
                                           input logic [CHAN_W-1:0] e);
        logic [CHAN_W-1:0] mag;
        logic [3:0]        quot;
        mag  = (q >= e) ? (q - e) : (e - q);
        quot = mag[CHAN_W-1:2];
        return 8'(quot * quot);
    endfunction

    // Load address, dropped when beyond the palette
    assign wr_addr_ext = {{IDX_W{1'b0}}, entry_index};
    assign wr_addr     = wr_addr_ext[IDX_W-1:0];
    assign wr_in_range = 32'(entry_index) < PALETTE_ENTRIES;

    // Palette memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load && wr_in_range)
        begin
            mem[wr_addr] <= {blue, green, red};
        end
        if (cmd.scan)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    // Capture query color
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            qry_r_reg <= red;
            qry_g_reg <= green;
            qry_b_reg <= blue;
        end
        if (cmd.scan)
        begin
            rd_idx_reg <= addr_reg;
        end
    end

    // Distance of the entry read last cycle
    assign distance = DIST_W'(chan_sq(qry_r_reg, rd_data_reg[CHAN_W-1:0]))
                    + DIST_W'(chan_sq(qry_g_reg, rd_data_reg[2*CHAN_W-1:CHAN_W]))
                    + DIST_W'(chan_sq(qry_b_reg, rd_data_reg[3*CHAN_W-1:2*CHAN_W]));
    assign better = BEST_W'(distance) < best_reg;

    // Scan address, compare valid and running minimum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            best_reg      <= START_BOUND;
            best_idx_reg  <= '0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan;
            if (cmd.start)
            begin
                addr_reg     <= '0;
                best_reg     <= START_BOUND;
                best_idx_reg <= '0;
            end
            else
            begin
                if (cmd.scan)
                begin
                    addr_reg <= addr_reg + 1'b1;
                end
                if (cmp_valid_reg && better)
                begin
                    best_reg     <= BEST_W'(distance);
                    best_idx_reg <= rd_idx_reg;
                end
            end
        end
    end

    // Output register keeps the low 6 bits of the winning index
    assign best_idx_ext = {{CHAN_W{1'b0}}, best_idx_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= best_idx_ext[CHAN_W-1:0];
        end
    end

    assign status.last_addr = (addr_reg == LAST_IDX);
    assign nearest_index    = out_data_reg;

endmodule

### rtl/nearest_palette_color_search.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Palette store with a nearest-color query over quantized RGB distance.
//
// A beat with tuser = 0 loads one palette entry and produces no result.
// A beat with tuser = 1 queries a color: the block walks the palette
// through its single memory read port, one entry per cycle, then raises
// m_tvalid with the lowest index of smallest distance as the input becomes
// ready for its next beat (after any wait on m_tready for an earlier result
// still in the output register). The distance is the sum of squares of
// each channel difference divided by 4, truncated toward zero.
// Palette contents are undefined after reset; load every entry before the
// first query. The input side is busy during a query; loads are accepted
// while a finished result waits on the output register.
// ----------------------------------------------------------------------------
module nearest_palette_color_search
    import npc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // entry_index[5:0], red[11:6], green[17:12], blue[23:18]
    input  logic        s_tuser,   // func: 0 load, 1 query
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // nearest_index[5:0], zero[7:6]
);

    npc_cmd_t          cmd;
    npc_status_t       status;
    logic [CHAN_W-1:0] nearest_index;

    npc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_func   (s_tuser),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .status    (status),
        .cmd       (cmd)
    );

    npc_dpath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .entry_index   (s_tdata[5:0]),
        .red           (s_tdata[11:6]),
        .green         (s_tdata[17:12]),
        .blue          (s_tdata[23:18]),
        .nearest_index (nearest_index)
    );

    assign m_tdata = {2'b00, nearest_index};

`ifndef ASSERT_OFF
    // A query keeps the input side busy for the whole scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == FUNC_QUERY) |=> !s_tready)
        else $error("input accepted during palette scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == FUNC_QUERY) |-> ##PALETTE_ENTRIES !s_tready)
        else $error("scan finished early");

    // A new result appears only at the end of a query
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised without a query");

    // A load never produces a result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == FUNC_LOAD && !m_tvalid) |=> !m_tvalid)
        else $error("load produced a result");
`endif

endmodule

### tb/palette_search_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_search_checker
// Watches both stream channels of the nearest palette color search block.
// Load beats update a private copy of the palette; query beats are scored
// against that copy and the winning index is queued. Every result beat is
// compared with the oldest queued index, and each mismatch is counted.
// ----------------------------------------------------------------------------
module palette_search_checker
    import npc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // entry_index[5:0], red[11:6], green[17:12], blue[23:18]
    input  logic        s_tuser,   // func: 0 load, 1 query
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // nearest_index[5:0], zero[7:6]
    output int          fail_count,
    output int          pending_count
);

    // Input beat layout, highest field first
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] entry_index;
    } palette_beat_t;

    logic [WORD_W-1:0] palette_copy [PALETTE_ENTRIES];
    logic [CHAN_W-1:0] expected_index_q [$];
    palette_beat_t     in_beat;
    logic [CHAN_W-1:0] want_index;

    // Channel difference divided by 4, truncated toward zero
    function automatic int quant_diff(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
        int diff;
        diff = int'(a) - int'(b);
        return diff / 4;
    endfunction

    // Scan the palette copy for the lowest index with the smallest distance
    function automatic logic [CHAN_W-1:0] nearest_entry(input palette_beat_t q);
        int best_dist;
        int best_k;
        int dr;
        int dg;
        int db;
        int distance;
        best_dist = int'(START_BOUND);
        best_k    = 0;
        for (int k = 0; k < PALETTE_ENTRIES; k++)
        begin
            dr       = quant_diff(q.red,   palette_copy[k][5:0]);
            dg       = quant_diff(q.green, palette_copy[k][11:6]);
            db       = quant_diff(q.blue,  palette_copy[k][17:12]);
            distance = dr * dr + dg * dg + db * db;
            if (distance < best_dist)
            begin
                best_dist = distance;
                best_k    = k;
            end
        end
        return CHAN_W'(best_k);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Compare a result beat with the oldest waiting query
            if (m_tvalid && m_tready)
            begin
                if (expected_index_q.size() == 0)
                    report_mismatch($sformatf("result index %0d with no query waiting",
                                              m_tdata[5:0]));
                else
                begin
                    want_index = expected_index_q.pop_front();
                    if (m_tdata[5:0] != want_index)
                        report_mismatch($sformatf("nearest_index got %0d, expected %0d",
                                                  m_tdata[5:0], want_index));
                    if (m_tdata[7:6] != 2'b00)
                        report_mismatch($sformatf("result pad bits got %b, expected 00",
                                                  m_tdata[7:6]));
                end
            end

            // Track loads, predict queries
            if (s_tvalid && s_tready)
            begin
                in_beat = s_tdata;
                if (s_tuser == FUNC_LOAD)
                begin
                    if (in_beat.entry_index < PALETTE_ENTRIES)
                        palette_copy[in_beat.entry_index] =
                            {in_beat.blue, in_beat.green, in_beat.red};
                end
                else
                    expected_index_q.push_back(nearest_entry(in_beat));
            end

            pending_count = expected_index_q.size();
        end
    end

endmodule

### tb/nearest_palette_color_search_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_palette_color_search_test
// Stimulus and verdict for the nearest palette color search block.
// Fills the whole palette, runs a directed set of loads and queries around
// exact matches, ties and truncation edges, then random loads and queries
// under several idle and stall patterns. A checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_test
    import npc_pkg::*;
();

    localparam int PALETTE_ENTRIES = 64;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int PHASE_ITEMS     = 105;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // entry_index[5:0], red[11:6], green[17:12], blue[23:18]
    logic        s_tuser;   // func: 0 load, 1 query
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // nearest_index[5:0], zero[7:6]

    int fail_count;
    int pending_count;
    int cycle_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    nearest_palette_color_search #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    palette_search_checker #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stall the result side at random
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Stop a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Drive one beat, hold it until accepted, return at the next falling edge
    task automatic send_beat(input logic func, input logic [23:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_entry(input logic [5:0] idx, input logic [5:0] r,
                              input logic [5:0] g, input logic [5:0] b);
        send_beat(FUNC_LOAD, {b, g, r, idx});
    endtask

    // Entry index is ignored on a query; fill it with noise
    task automatic query_color(input logic [5:0] r, input logic [5:0] g, input logic [5:0] b);
        send_beat(FUNC_QUERY, {b, g, r, 6'($urandom_range(63))});
    endtask

    // Coarse channels come from a few levels so that duplicates and ties show up
    function automatic logic [5:0] pick_channel(input bit coarse);
        logic [6:0] v;
        v = coarse ? 7'($urandom_range(4) * 16) : 7'($urandom_range(63));
        return (v > 7'd63) ? 6'd63 : v[5:0];
    endfunction

    // A coarse level nudged by up to 3, where truncation decides the distance
    function automatic logic [5:0] near_channel();
        int v;
        v = int'(pick_channel(1'b1)) + int'($urandom_range(6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 63)
            v = 63;
        return 6'(v);
    endfunction

    task automatic random_item();
        bit coarse;
        coarse = ($urandom_range(99) < 35);
        if ($urandom_range(99) < 55)
            load_entry(6'($urandom_range(63)), pick_channel(coarse),
                       pick_channel(coarse), pick_channel(coarse));
        else if (coarse)
            query_color(near_channel(), near_channel(), near_channel());
        else
            query_color(pick_channel(1'b0), pick_channel(1'b0), pick_channel(1'b0));
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = FUNC_LOAD;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill every entry before the first query
        for (int k = 0; k < PALETTE_ENTRIES; k++)
            load_entry(6'(k), pick_channel(1'b0), pick_channel(1'b0), pick_channel(1'b0));

        // Directed: extremes, exact matches, ties, truncation edges
        load_entry(6'd0, 6'd0, 6'd0, 6'd0);
        load_entry(6'd63, 6'd63, 6'd63, 6'd63);
        query_color(6'd0, 6'd0, 6'd0);
        query_color(6'd63, 6'd63, 6'd63);
        query_color(6'd3, 6'd3, 6'd3);
        load_entry(6'd17, 6'd40, 6'd20, 6'd10);
        load_entry(6'd33, 6'd40, 6'd20, 6'd10);
        query_color(6'd40, 6'd20, 6'd10);
        query_color(6'd43, 6'd17, 6'd13);
        query_color(6'd37, 6'd23, 6'd7);
        query_color(6'd36, 6'd24, 6'd6);
        load_entry(6'd5, 6'd63, 6'd0, 6'd63);
        query_color(6'd63, 6'd0, 6'd63);
        query_color(6'd0, 6'd63, 6'd0);
        load_entry(6'd62, 6'd1, 6'd62, 6'd1);
        query_color(6'd0, 6'd63, 6'd0);
        load_entry(6'd42, 6'd21, 6'd42, 6'd21);
        query_color(6'd21, 6'd42, 6'd21);

        // Random: no idling, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 73 : (phase == 3) ? 14 : 0;
            recv_stall_pct = (phase == 2) ? 73 : (phase == 3) ? 14 : 0;
            repeat (PHASE_ITEMS)
                random_item();
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then let the block settle
        while (pending_count != 0)
            @(negedge clk);
        repeat (PALETTE_ENTRIES + 8) @(negedge clk);

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
